// ----- hdl/prq_pkg.sv -----
// ============================================================================
// prq_pkg - shared types and codes for the priority ready-queue scheduler
// Holds the operation and status codes and the transaction payload structs.
// ============================================================================
package prq_pkg;

    localparam int OPCODE_W   = 3;
    localparam int TASK_ID_W  = 5;
    localparam int PRIORITY_W = 3;
    localparam int STATUS_W   = 2;

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_SPAWN      = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_SCHEDULE   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_DESCHEDULE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP        = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_YIELD      = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_SET_PRIO   = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_RAISE_PRIO = 3'd6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_EFFECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RUNNABLE  = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0]   opcode;
        logic [TASK_ID_W-1:0]  task_id;
        logic [PRIORITY_W-1:0] new_priority;
    } t_op_item;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [TASK_ID_W-1:0]  picked_task;
        logic [PRIORITY_W-1:0] picked_priority;
        logic                  any_ready;
    } t_res_item;

endpackage

// ----- hdl/prq_ifs.sv -----
// ============================================================================
// prq_ifs - valid/ready channels of the priority ready-queue scheduler
// One interface for operation transactions and one for result transactions.
// ============================================================================
interface prq_op_if;
    logic               valid;
    logic               ready;
    prq_pkg::t_op_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface prq_res_if;
    logic               valid;
    logic               ready;
    prq_pkg::t_res_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/priority_ready_queue_scheduler.sv -----
// ============================================================================
// priority_ready_queue_scheduler - multilevel FIFO ready queue with bitmap
// Keeps one doubly linked FIFO of tasks per priority level, a bitmap of the
// non-empty levels and a level and runnable flag for every task.
// ============================================================================
//
//  Channel  | Dir | Payload                                          | Per op
//  ---------+-----+--------------------------------------------------+-------
//  i_op     | in  | opcode, task_id, new_priority                    | one
//  o_res    | out | status, picked_task, picked_priority, any_ready  | one
//
// Every operation transaction yields exactly one result transaction. The
// block sustains one transaction per cycle while the result channel does not
// stall. An accepted operation waits in the input register until it executes,
// and its result is then loaded into the result register. Each operation is a
// single update pass over the flop-based link, end and bitmap registers,
// which the next operation must see. Reset is synchronous and active low; it
// empties the bitmap and clears every task's level and runnable flag at once,
// so no clearing pass is needed. A stalled result holds its register, and the
// input register keeps accepting as long as the result register can move.

module priority_ready_queue_scheduler #(
    parameter int NUM_TASKS  = 32,
    parameter int NUM_LEVELS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    prq_op_if.sink         i_op,
    prq_res_if.source      o_res
);

    localparam int LW = $clog2(NUM_LEVELS);
    localparam int TW = $clog2(NUM_TASKS);

    // ------------------------------------------------------------------
    // Scheduler state. The list ends and links hold meaningful values only
    // while the matching list owns them, so they carry no reset.
    // ------------------------------------------------------------------
    logic [NUM_LEVELS-1:0] r_ready,  n_ready;
    logic [TW-1:0]         r_head   [NUM_LEVELS];
    logic [TW-1:0]         n_head   [NUM_LEVELS];
    logic [TW-1:0]         r_tail   [NUM_LEVELS];
    logic [TW-1:0]         n_tail   [NUM_LEVELS];
    logic [TW-1:0]         r_next   [NUM_TASKS];
    logic [TW-1:0]         n_next   [NUM_TASKS];
    logic [TW-1:0]         r_prev   [NUM_TASKS];
    logic [TW-1:0]         n_prev   [NUM_TASKS];
    logic [LW-1:0]         r_level  [NUM_TASKS];
    logic [LW-1:0]         n_level  [NUM_TASKS];
    logic [NUM_TASKS-1:0]  r_queued, n_queued;

    // Input and result registers.
    logic                  r_in_valid;
    prq_pkg::t_op_item     r_op;
    logic                  r_out_valid;
    prq_pkg::t_res_item    r_res;
    prq_pkg::t_res_item    n_res;

    logic                  fire;

    // The operation in the input register executes whenever the result
    // register is free or is being emptied in this cycle.
    assign fire        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_op.ready  = !r_in_valid || fire;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    // ------------------------------------------------------------------
    // Operand preparation.
    // ------------------------------------------------------------------
    logic [TW-1:0] t_idx;
    logic          t_ok;
    logic [LW-1:0] np;
    logic [LW-1:0] cur_lvl;
    logic          cur_q;
    logic          any_cur;
    logic [LW-1:0] first_lvl;

    assign t_idx   = TW'(r_op.task_id);
    assign t_ok    = 32'(r_op.task_id) < NUM_TASKS;
    // Levels beyond the last one saturate to the least urgent level.
    assign np      = (32'(r_op.new_priority) < NUM_LEVELS) ? LW'(r_op.new_priority)
                                                            : LW'(NUM_LEVELS - 1);
    assign cur_lvl = r_level[t_idx];
    assign cur_q   = r_queued[t_idx];
    assign any_cur = |r_ready;

    // Find-first-set over the bitmap: the lowest set bit is the most urgent.
    always_comb begin
        first_lvl = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (r_ready[i]) begin
                first_lvl = LW'(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // Operation decode: every opcode reduces to an optional unlink of one
    // task followed by an optional enqueue of the addressed task.
    // ------------------------------------------------------------------
    logic                     u_en;
    logic [TW-1:0]            u_t;
    logic [LW-1:0]            u_lvl;
    logic                     e_en;
    logic [LW-1:0]            e_lvl;
    logic                     lvl_we;
    logic                     pick;
    logic [prq_pkg::STATUS_W-1:0] status;

    always_comb begin
        u_en   = 1'b0;
        u_t    = t_idx;
        u_lvl  = cur_lvl;
        e_en   = 1'b0;
        e_lvl  = cur_lvl;
        lvl_we = 1'b0;
        pick   = 1'b0;
        status = prq_pkg::ST_NO_EFFECT;

        if (r_op.opcode == prq_pkg::OP_POP) begin
            if (!any_cur) begin
                status = prq_pkg::ST_EMPTY;
            end else begin
                u_en   = 1'b1;
                u_t    = r_head[first_lvl];
                u_lvl  = first_lvl;
                pick   = 1'b1;
                status = prq_pkg::ST_DONE;
            end
        end else if (t_ok) begin
            unique case (r_op.opcode) inside
                prq_pkg::OP_SPAWN: begin
                    if (cur_q) begin
                        status = prq_pkg::ST_RUNNABLE;
                    end else begin
                        lvl_we = 1'b1;
                        e_en   = 1'b1;
                        e_lvl  = np;
                        status = prq_pkg::ST_DONE;
                    end
                end
                prq_pkg::OP_SCHEDULE: begin
                    if (cur_q) begin
                        status = prq_pkg::ST_RUNNABLE;
                    end else begin
                        e_en   = 1'b1;
                        status = prq_pkg::ST_DONE;
                    end
                end
                prq_pkg::OP_DESCHEDULE: begin
                    if (cur_q) begin
                        u_en   = 1'b1;
                        status = prq_pkg::ST_DONE;
                    end
                end
                prq_pkg::OP_YIELD: begin
                    // Requeue only when some ready level is at least as urgent.
                    if (cur_q) begin
                        status = prq_pkg::ST_RUNNABLE;
                    end else if (any_cur && (first_lvl <= cur_lvl)) begin
                        e_en   = 1'b1;
                        status = prq_pkg::ST_DONE;
                    end
                end
                prq_pkg::OP_SET_PRIO, prq_pkg::OP_RAISE_PRIO: begin
                    // Raise only takes effect for a strictly more urgent level.
                    if ((r_op.opcode == prq_pkg::OP_SET_PRIO) || (np < cur_lvl)) begin
                        status = prq_pkg::ST_DONE;
                        e_lvl  = np;
                        if (cur_lvl != np) begin
                            lvl_we = 1'b1;
                            if (cur_q) begin
                                u_en = 1'b1;
                                e_en = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    status = prq_pkg::ST_NO_EFFECT;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Next state: unlink first, then enqueue, each seeing the one before.
    // ------------------------------------------------------------------
    logic          u_is_head;
    logic          u_is_tail;
    logic [TW-1:0] u_nx;
    logic [TW-1:0] u_pv;
    logic [TW-1:0] e_tl;

    assign u_is_head = (r_head[u_lvl] == u_t);
    assign u_is_tail = (r_tail[u_lvl] == u_t);
    assign u_nx      = r_next[u_t];
    assign u_pv      = r_prev[u_t];

    always_comb begin
        n_ready  = r_ready;
        n_head   = r_head;
        n_tail   = r_tail;
        n_next   = r_next;
        n_prev   = r_prev;
        n_level  = r_level;
        n_queued = r_queued;

        if (u_en) begin
            if (u_is_head && u_is_tail) begin
                n_ready[u_lvl] = 1'b0;
            end else begin
                if (u_is_head) begin
                    n_head[u_lvl] = u_nx;
                end else begin
                    n_next[u_pv] = u_nx;
                end
                if (u_is_tail) begin
                    n_tail[u_lvl] = u_pv;
                end else begin
                    n_prev[u_nx] = u_pv;
                end
            end
            n_queued[u_t] = 1'b0;
        end

        if (lvl_we) begin
            n_level[t_idx] = e_lvl;
        end

        e_tl = n_tail[e_lvl];
        if (e_en) begin
            if (n_ready[e_lvl]) begin
                n_next[e_tl]  = t_idx;
                n_prev[t_idx] = e_tl;
            end else begin
                n_head[e_lvl] = t_idx;
                n_prev[t_idx] = t_idx;
            end
            n_next[t_idx]   = t_idx;
            n_tail[e_lvl]   = t_idx;
            n_ready[e_lvl]  = 1'b1;
            n_queued[t_idx] = 1'b1;
        end
    end

    always_comb begin
        n_res.status          = status;
        n_res.picked_task     = pick ? prq_pkg::TASK_ID_W'(u_t) : '0;
        n_res.picked_priority = pick ? prq_pkg::PRIORITY_W'(first_lvl) : '0;
        n_res.any_ready       = |n_ready;
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_op.ready) begin
                r_in_valid <= i_op.valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.valid && i_op.ready) begin
            r_op <= i_op.data;
        end
        if (fire) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready  <= '0;
            r_queued <= '0;
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_level[i] <= '0;
            end
        end else if (fire) begin
            r_ready  <= n_ready;
            r_queued <= n_queued;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_next <= n_next;
            r_prev <= n_prev;
        end
    end

endmodule

// ----- hdl/prq_checker.sv -----
// ============================================================================
// prq_checker - port-level checks for the priority ready-queue scheduler
// Watches the operation and result channels and is bound to the top level.
// ============================================================================
module prq_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  prq_pkg::t_res_item i_out_data
);

    // Reset empties the result register.
    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // With no result pending, the block must accept an operation.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("operation stalled with empty result register");

    // Every accepted transaction is followed by a valid result.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> ##1 i_out_valid)
        else $error("no result for an accepted operation");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");

    // An empty-queue pop reports nothing picked and nothing ready.
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_data.status == prq_pkg::ST_EMPTY)) |->
        (!i_out_data.any_ready && (i_out_data.picked_task == '0)
         && (i_out_data.picked_priority == '0)))
        else $error("empty pop reported a task or a ready level");

endmodule

bind priority_ready_queue_scheduler prq_checker u_prq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_op.valid),
    .i_in_ready  (i_op.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);
